>>> rtl/frc_pkg.sv
// Shared types and constants of the framed command receiver.
`default_nettype none

package frc_pkg;

    // Default depth of the receive byte store
    localparam int BUF_DEPTH_DEF = 64;

    // Frame rules
    localparam int unsigned MIN_FRAME = 5;
    localparam logic [5:0]  LEN_CAP   = 6'd61;
    localparam logic [7:0]  LEN_MIN   = 8'd2;

    // Input op codes (s_tuser)
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds (m_tuser)
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // Configuration register indexes
    localparam logic [7:0] REG_HEADER  = 8'd0;
    localparam logic [7:0] REG_TAIL    = 8'd1;
    localparam logic [7:0] REG_TIMEOUT = 8'd2;
    localparam logic [7:0] REG_MAXLEN  = 8'd3;

    // Register reset values
    localparam logic [7:0]  HEADER_RST  = 8'd170;
    localparam logic [7:0]  TAIL_RST    = 8'd85;
    localparam logic [15:0] TIMEOUT_RST = 16'd10;
    localparam logic [5:0]  MAXLEN_RST  = 6'd20;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_STATUS,
        ST_FETCH,
        ST_SEND
    } frc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic in_accept;
        logic start;
        logic scan;
        logic check;
        logic fetch;
        logic load_status;
        logic load_data;
    } frc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic trig;
        logic scan_done;
        logic frame_ok;
        logic dlen_zero;
        logic data_last;
        logic out_free;
    } frc_status_t;

endpackage

`default_nettype wire

>>> rtl/frc_ctrl.sv
// Controller state machine of the framed command receiver.
`default_nettype none

module frc_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire frc_pkg::frc_status_t status,
    output frc_pkg::frc_cmd_t        cmd
);
    import frc_pkg::*;

    frc_state_t state_reg;
    frc_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && status.trig)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_STATUS;
            end
            ST_STATUS:
            begin
                if (status.out_free)
                begin
                    if (status.frame_ok && !status.dlen_zero)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    if (status.data_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready        = 1'b0;
        cmd             = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.in_accept = s_tvalid;
                cmd.start     = s_tvalid && status.trig;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            ST_STATUS:
            begin
                cmd.load_status = status.out_free;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            ST_SEND:
            begin
                cmd.load_data = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/frc_datapath.sv
// Datapath of the framed command receiver: byte store, counters, frame check, result register.
`default_nettype none

module frc_datapath
#(
    parameter int BUF_DEPTH = frc_pkg::BUF_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [7:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic                 s_tuser,
    input  wire logic [7:0]           s_tdata,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [23:0]               m_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast,
    input  wire frc_pkg::frc_cmd_t    cmd,
    output frc_pkg::frc_status_t      status
);
    import frc_pkg::*;

    localparam int ADDR_W = $clog2(BUF_DEPTH);
    localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > 8) ? CNT_W : 8) + 2;

    // Configuration registers
    logic [7:0]  header_reg;
    logic [7:0]  tail_cfg_reg;
    logic [15:0] timeout_reg;
    logic [5:0]  maxlen_reg;

    // Store and counters
    logic [7:0]        mem [BUF_DEPTH];
    logic [7:0]        rdata_reg;
    logic [CNT_W-1:0]  fill_reg,  fill_next;
    logic [15:0]       idle_reg,  idle_next;
    logic [15:0]       idle_inc;
    logic              fill_full;

    // Scan state
    logic [CNT_W-1:0]  scan_addr_reg, scan_addr_next;
    logic              scan_more;
    logic              rd_v_reg,  rd_v_next;
    logic [ADDR_W-1:0] rd_pos_reg, rd_pos_next;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] hdr_reg,   hdr_next;
    logic [7:0]        len_reg,   len_next;
    logic [7:0]        xor_reg,   xor_next;
    logic [7:0]        cmdb_reg,  cmdb_next;
    logic [7:0]        chk_reg,   chk_next;
    logic [7:0]        tail_reg,  tail_next;
    logic [ADDR_W-1:0] rel;
    logic [CMP_W-1:0]  rel_w;
    logic [CMP_W-1:0]  len_w;

    // Verdict and data walk
    logic              ok_reg,    ok_next;
    logic [5:0]        dlen_reg,  dlen_next;
    logic [ADDR_W-1:0] ptr_reg,   ptr_next;
    logic [5:0]        remain_reg, remain_next;
    logic [CMP_W-1:0]  rest_w;
    logic [5:0]        limit;
    logic              verdict;

    // Result register
    logic              out_valid_reg;
    logic              out_kind_reg;
    logic              out_ok_reg;
    logic [7:0]        out_cmd_reg;
    logic [5:0]        out_dlen_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg   <= HEADER_RST;
            tail_cfg_reg <= TAIL_RST;
            timeout_reg  <= TIMEOUT_RST;
            maxlen_reg   <= MAXLEN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HEADER:  header_reg   <= cfg_data[7:0];
                REG_TAIL:    tail_cfg_reg <= cfg_data[7:0];
                REG_TIMEOUT: timeout_reg  <= cfg_data;
                REG_MAXLEN:  maxlen_reg   <= cfg_data[5:0];
                default:     header_reg   <= header_reg;
            endcase
        end
    end

    // Fill and idle counters
    assign fill_full = (fill_reg == CNT_W'(BUF_DEPTH));
    assign idle_inc  = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign status.trig = (s_tuser == OP_TICK) && (fill_reg != '0) && (idle_inc >= timeout_reg);

    always_comb
    begin
        fill_next = fill_reg;
        idle_next = idle_reg;
        if (cmd.in_accept)
        begin
            if (s_tuser == OP_BYTE)
            begin
                if (!fill_full)
                begin
                    fill_next = fill_reg + CNT_W'(1);
                    idle_next = '0;
                end
            end
            else if (status.trig)
            begin
                idle_next = '0;
            end
            else
            begin
                idle_next = idle_inc;
            end
        end
        if (cmd.check)
        begin
            fill_next = '0;
        end
    end

    // Store write port
    always_ff @(posedge clk)
    begin
        if (cmd.in_accept && (s_tuser == OP_BYTE) && !fill_full)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= s_tdata;
        end
    end

    // Store read port, registered
    assign scan_more = (scan_addr_reg < fill_reg);
    assign rd_en     = cmd.fetch || (cmd.scan && scan_more);
    assign rd_addr   = cmd.fetch ? ptr_reg : scan_addr_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Scan: read address sequencing
    always_comb
    begin
        scan_addr_next = scan_addr_reg;
        rd_v_next      = 1'b0;
        rd_pos_next    = rd_pos_reg;
        if (cmd.start)
        begin
            scan_addr_next = '0;
        end
        else if (cmd.scan && scan_more)
        begin
            scan_addr_next = scan_addr_reg + CNT_W'(1);
            rd_v_next      = 1'b1;
            rd_pos_next    = scan_addr_reg[ADDR_W-1:0];
        end
    end

    assign status.scan_done = rd_v_reg && ((CNT_W'(rd_pos_reg) + CNT_W'(1)) == fill_reg);

    // Scan: header search and frame field capture, one byte a cycle
    assign rel   = rd_pos_reg - hdr_reg;
    assign rel_w = CMP_W'(rel);
    assign len_w = CMP_W'(len_reg);

    always_comb
    begin
        found_next = found_reg;
        hdr_next   = hdr_reg;
        len_next   = len_reg;
        xor_next   = xor_reg;
        cmdb_next  = cmdb_reg;
        chk_next   = chk_reg;
        tail_next  = tail_reg;
        if (cmd.start)
        begin
            found_next = 1'b0;
        end
        else if (rd_v_reg)
        begin
            if (!found_reg)
            begin
                if (rdata_reg == header_reg)
                begin
                    found_next = 1'b1;
                    hdr_next   = rd_pos_reg;
                end
            end
            else if (rel_w == CMP_W'(1))
            begin
                len_next = rdata_reg;
                xor_next = rdata_reg;
            end
            else
            begin
                if (rel_w <= len_w)
                begin
                    xor_next = xor_reg ^ rdata_reg;
                end
                if (rel_w == CMP_W'(2))
                begin
                    cmdb_next = rdata_reg;
                end
                if (rel_w == len_w + CMP_W'(1))
                begin
                    chk_next = rdata_reg;
                end
                if (rel_w == len_w + CMP_W'(2))
                begin
                    tail_next = rdata_reg;
                end
            end
        end
    end

    // Frame verdict
    assign rest_w = CMP_W'(fill_reg) - CMP_W'(hdr_reg);
    assign limit  = (maxlen_reg < LEN_CAP) ? maxlen_reg : LEN_CAP;
    assign verdict = found_reg
                  && (rest_w >= CMP_W'(MIN_FRAME))
                  && (len_reg >= LEN_MIN)
                  && (len_reg <= {2'b00, limit})
                  && (rest_w >= len_w + CMP_W'(3))
                  && (tail_reg == tail_cfg_reg)
                  && (xor_reg == chk_reg);

    // Verdict latch and data byte walk
    always_comb
    begin
        ok_next     = ok_reg;
        dlen_next   = dlen_reg;
        ptr_next    = ptr_reg;
        remain_next = remain_reg;
        if (cmd.check)
        begin
            ok_next     = verdict;
            dlen_next   = verdict ? 6'(len_reg - LEN_MIN) : 6'd0;
            ptr_next    = ADDR_W'(CMP_W'(hdr_reg) + CMP_W'(3));
            remain_next = verdict ? 6'(len_reg - LEN_MIN) : 6'd0;
        end
        if (cmd.fetch)
        begin
            ptr_next = ptr_reg + ADDR_W'(1);
        end
        if (cmd.load_data)
        begin
            remain_next = remain_reg - 6'd1;
        end
    end

    assign status.frame_ok  = ok_reg;
    assign status.dlen_zero = (dlen_reg == 6'd0);
    assign status.data_last = (remain_reg == 6'd1);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            idle_reg      <= '0;
            scan_addr_reg <= '0;
            rd_v_reg      <= 1'b0;
            found_reg     <= 1'b0;
            ok_reg        <= 1'b0;
            remain_reg    <= '0;
        end
        else
        begin
            fill_reg      <= fill_next;
            idle_reg      <= idle_next;
            scan_addr_reg <= scan_addr_next;
            rd_v_reg      <= rd_v_next;
            found_reg     <= found_next;
            ok_reg        <= ok_next;
            remain_reg    <= remain_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_pos_reg <= rd_pos_next;
        hdr_reg    <= hdr_next;
        len_reg    <= len_next;
        xor_reg    <= xor_next;
        cmdb_reg   <= cmdb_next;
        chk_reg    <= chk_next;
        tail_reg   <= tail_next;
        dlen_reg   <= dlen_next;
        ptr_reg    <= ptr_next;
    end

    // Result register
    assign out_free        = !out_valid_reg || m_tready;
    assign status.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_status || cmd.load_data)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_status)
        begin
            out_kind_reg <= KIND_STATUS;
            out_ok_reg   <= ok_reg;
            out_cmd_reg  <= ok_reg ? cmdb_reg : 8'd0;
            out_dlen_reg <= dlen_reg;
            out_byte_reg <= 8'd0;
            out_last_reg <= !ok_reg || (dlen_reg == 6'd0);
        end
        else if (cmd.load_data)
        begin
            out_kind_reg <= KIND_DATA;
            out_ok_reg   <= 1'b1;
            out_cmd_reg  <= cmdb_reg;
            out_dlen_reg <= dlen_reg;
            out_byte_reg <= rdata_reg;
            out_last_reg <= (remain_reg == 6'd1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_byte_reg, out_dlen_reg, out_cmd_reg, out_ok_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/framed_command_receiver.sv
// Top level of the framed command receiver.
//
//  channel  | dir | handshake          | content
//  ---------+-----+--------------------+--------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | one word: received byte or time tick
//  m_*      | out | m_tvalid/m_tready  | status word, then one word per data byte
//  cfg_*    | in  | cfg_valid/cfg_ready| register index and write data
//
// A byte word or a tick that starts no parse is accepted while the receiver is idle. A
// parse attempt walks the byte store through its single read port: after the tick it
// scans the stored bytes, checks the frame, sends the status word, then fetches and sends each data byte.
// s_tready is low for the whole parse; a stalled m_tready holds the walk. Reset clears
// counters and control registers and loads configuration defaults; the store needs no clearing pass.
`default_nettype none

module framed_command_receiver
#(
    parameter int BUF_DEPTH = frc_pkg::BUF_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] op
    // Result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [0] ok, [8:1] command, [14:9] payload_len,
                                        // [22:15] data_byte, [23] zero
    output logic             m_tuser,   // [0] kind
    output logic             m_tlast,
    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import frc_pkg::*;

    frc_cmd_t    cmd;
    frc_status_t status;

    assign cfg_ready = 1'b1;

    // Controller
    frc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    frc_datapath
    #(
        .BUF_DEPTH (BUF_DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    // A started parse blocks the input side on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !s_tready)
    else $error("input still ready after parse start");

    // A failed frame gives a single, final status word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_STATUS) && !m_tdata[0]) |-> m_tlast)
    else $error("failed status word not marked last");

    // Data words only follow an accepted frame with data
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_DATA)) |-> (m_tdata[0] && (m_tdata[14:9] != 6'd0)))
    else $error("data word without accepted frame");

    // No result word is loaded while the input side is open
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_status || cmd.load_data) |-> !s_tready)
    else $error("result loaded while accepting input");

endmodule

`default_nettype wire
